// ===== hw/rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int CHANNEL_BITS    = 8;
  localparam int NUM_CH          = 4;
  localparam int SUM_BITS        = CHANNEL_BITS + 1;
  localparam int AVG_BITS        = CHANNEL_BITS + 3;
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT      = 4096;
  localparam int MIN_DIM         = 2;
  localparam int WIDTH_REG_BITS  = 12;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int ROW_BITS        = 12;
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 13;
  localparam int ROUND_ADD       = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_WITH_ALPHA   = 2'd2
  } cfg_index_t;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [SUM_BITS-1:0]     psum_t;
  typedef chan_t [NUM_CH-1:0]      pixel_t;
  typedef psum_t [NUM_CH-1:0]      pair_word_t;

  typedef struct packed {
    logic       load;
    pair_word_t hs;
    logic       eof;
    logic       alpha_en;
  } rbd_issue_t;

endpackage

// ===== hw/rtl/rbd_pix_if.sv =====
// ----------------------------------------------------------------------------
// rbd_pix_if
// Input pixel channel: valid/ready with one RGBA word.
// ----------------------------------------------------------------------------
interface rbd_pix_if
  import rbd_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;
  chan_t in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  input in_alpha, output ready);
endinterface

// ===== hw/rtl/rbd_res_if.sv =====
// ----------------------------------------------------------------------------
// rbd_res_if
// Result channel: valid/ready with one averaged RGBA word and frame end flag.
// ----------------------------------------------------------------------------
interface rbd_res_if
  import rbd_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  chan_t out_alpha;
  logic  end_of_frame;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output end_of_frame, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/rbd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rbd_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface rbd_cfg_if
  import rbd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rbd_line_mem.sv =====
// ----------------------------------------------------------------------------
// rbd_line_mem
// Single-port line store of horizontal pair sums, registered read.
// ----------------------------------------------------------------------------
module rbd_line_mem
  import rbd_pkg::*;
#(
  parameter int DEPTH     = MAX_WIDTH_DEF / 2,
  parameter int ADDR_BITS = $clog2(MAX_WIDTH_DEF / 2)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] addr,
  input  pair_word_t           wdata,
  output pair_word_t           rdata
);

  pair_word_t mem [DEPTH];
  pair_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// Config registers, raster counters, left pixel hold, pair sums and line
// store commands.
// ----------------------------------------------------------------------------
module rbd_ctrl
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  rbd_pix_if.sink        in_ch,
  rbd_cfg_if.sink        cfg_ch,
  input  logic           in_ready_i,
  output rbd_issue_t     issue_o,
  output logic           mem_we_o,
  output logic           mem_re_o,
  output logic [((MAX_WIDTH / 2) > 1 ? $clog2(MAX_WIDTH / 2) : 1)-1:0] mem_addr_o,
  output pair_word_t     mem_wdata_o
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_BITS  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_BITS   = $clog2(MAX_WIDTH) + 1;
  localparam int PAIR_BITS  = COL_BITS - 1;
  localparam int W_CMP_BITS = (COL_BITS > WIDTH_REG_BITS) ? COL_BITS : WIDTH_REG_BITS;
  localparam int RST_WIDTH  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [COL_BITS-1:0]        eff_w_r, eff_w_nxt;
  logic [HEIGHT_REG_BITS-1:0] eff_h_r, eff_h_nxt;
  logic                       with_alpha_r, with_alpha_nxt;
  logic [COL_BITS-1:0]        col_r, col_nxt;
  logic [ROW_BITS-1:0]        row_r, row_nxt;
  pixel_t                     hold_r, hold_nxt;

  logic                       accept;
  logic                       cfg_hit;
  pixel_t                     px;
  pair_word_t                 hs;
  logic [PAIR_BITS-1:0]       pair;
  logic                       pair_ok;
  logic [COL_BITS-1:0]        col_p1;
  logic [HEIGHT_REG_BITS-1:0] row_p1;
  logic [COL_BITS-1:0]        last_col;
  logic [HEIGHT_REG_BITS-1:0] last_row;
  logic [W_CMP_BITS-1:0]      w_ext;
  logic [HEIGHT_REG_BITS-1:0] h_val;

  assign accept       = in_ch.valid && in_ready_i;
  assign in_ch.ready  = in_ready_i;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    px[0] = in_ch.in_red;
    px[1] = in_ch.in_green;
    px[2] = in_ch.in_blue;
    px[3] = with_alpha_r ? in_ch.in_alpha : '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (c < NUM_CH - 1 || with_alpha_r) begin
        hs[c] = SUM_BITS'(hold_r[c]) + SUM_BITS'(px[c]);
      end else begin
        hs[c] = '0;
      end
    end
  end

  assign pair     = col_r[COL_BITS-1:1];
  assign pair_ok  = pair < PAIR_BITS'(LINE_DEPTH);
  assign col_p1   = col_r + COL_BITS'(1);
  assign row_p1   = HEIGHT_REG_BITS'(row_r) + HEIGHT_REG_BITS'(1);
  assign last_col = {eff_w_r[COL_BITS-1:1], 1'b0} - COL_BITS'(1);
  assign last_row = {eff_h_r[HEIGHT_REG_BITS-1:1], 1'b0} - HEIGHT_REG_BITS'(1);

  assign mem_we_o    = accept && col_r[0] && pair_ok && !row_r[0];
  assign mem_re_o    = accept && col_r[0] && pair_ok && row_r[0];
  assign mem_addr_o  = pair[ADDR_BITS-1:0];
  assign mem_wdata_o = hs;

  assign issue_o.load     = mem_re_o;
  assign issue_o.hs       = hs;
  assign issue_o.eof      = (HEIGHT_REG_BITS'(row_r) == last_row) && (col_r == last_col);
  assign issue_o.alpha_en = with_alpha_r;

  assign w_ext = W_CMP_BITS'(cfg_ch.data[WIDTH_REG_BITS-1:0]);
  assign h_val = cfg_ch.data[HEIGHT_REG_BITS-1:0];

  always_comb begin
    eff_w_nxt      = eff_w_r;
    eff_h_nxt      = eff_h_r;
    with_alpha_nxt = with_alpha_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    hold_nxt       = hold_r;
    cfg_hit        = 1'b0;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IMAGE_WIDTH: begin
          cfg_hit = 1'b1;
          if (w_ext < W_CMP_BITS'(MIN_DIM)) begin
            eff_w_nxt = COL_BITS'(MIN_DIM);
          end else if (w_ext > W_CMP_BITS'(MAX_WIDTH)) begin
            eff_w_nxt = COL_BITS'(MAX_WIDTH);
          end else begin
            eff_w_nxt = COL_BITS'(w_ext);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_hit = 1'b1;
          if (h_val < HEIGHT_REG_BITS'(MIN_DIM)) begin
            eff_h_nxt = HEIGHT_REG_BITS'(MIN_DIM);
          end else if (h_val > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
            eff_h_nxt = HEIGHT_REG_BITS'(MAX_HEIGHT);
          end else begin
            eff_h_nxt = h_val;
          end
        end
        CFG_WITH_ALPHA: begin
          cfg_hit        = 1'b1;
          with_alpha_nxt = cfg_ch.data[0];
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (!col_r[0]) begin
        hold_nxt = px;
      end
      if (col_p1 >= eff_w_r) begin
        col_nxt = '0;
        if (row_p1 >= eff_h_r) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_p1[ROW_BITS-1:0];
        end
      end else begin
        col_nxt = col_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r      <= COL_BITS'(RST_WIDTH);
      eff_h_r      <= HEIGHT_REG_BITS'(HEIGHT_RESET);
      with_alpha_r <= 1'b1;
      col_r        <= '0;
      row_r        <= '0;
      hold_r       <= '0;
    end else begin
      eff_w_r      <= eff_w_nxt;
      eff_h_r      <= eff_h_nxt;
      with_alpha_r <= with_alpha_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      hold_r       <= hold_nxt;
    end
  end

endmodule

// ===== hw/rtl/rbd_avg.sv =====
// ----------------------------------------------------------------------------
// rbd_avg
// Adds stored and current pair sums, rounds the mean and holds the result
// word in the output register.
// ----------------------------------------------------------------------------
module rbd_avg
  import rbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rbd_issue_t issue_i,
  input  pair_word_t rdata_i,
  output logic       free_o,
  rbd_res_if.source  out_ch
);

  logic       s1_valid_r, s1_valid_nxt;
  pair_word_t s1_hs_r;
  logic       s1_eof_r;
  logic       s1_alpha_en_r;
  logic       out_valid_r, out_valid_nxt;
  pixel_t     out_px_r;
  logic       out_eof_r;

  logic                s1_adv;
  pixel_t              avg;
  logic [AVG_BITS-1:0] total;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign free_o = !s1_valid_r || s1_adv;

  always_comb begin
    total = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      total  = AVG_BITS'(s1_hs_r[c]) + AVG_BITS'(rdata_i[c]) + AVG_BITS'(ROUND_ADD);
      avg[c] = total[CHANNEL_BITS+1:2];
    end
    if (!s1_alpha_en_r) begin
      avg[NUM_CH-1] = '0;
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (issue_i.load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_i.load) begin
      s1_hs_r       <= issue_i.hs;
      s1_eof_r      <= issue_i.eof;
      s1_alpha_en_r <= issue_i.alpha_en;
    end
    if (s1_adv) begin
      out_px_r  <= avg;
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_red      = out_px_r[0];
  assign out_ch.out_green    = out_px_r[1];
  assign out_ch.out_blue     = out_px_r[2];
  assign out_ch.out_alpha    = out_px_r[3];
  assign out_ch.end_of_frame = out_eof_r;

endmodule

// ===== hw/rtl/rgba_box_downsample_2x2_unit.sv =====
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2_unit
// 2x2 box filter downsampler with rounding for RGB/RGBA pixel streams.
// ----------------------------------------------------------------------------
// throughput: one pixel word per cycle unless result back-pressure stalls it
// result path: stage register with line store read, then the output register
// reset clears counters, left hold and pipeline valids; config returns to
// 640 x 480 with alpha; the line store is not cleared and needs no sweep
module rgba_box_downsample_2x2_unit
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rbd_pix_if.sink   in_ch,
  rbd_cfg_if.sink   cfg_ch,
  rbd_res_if.source out_ch
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_BITS  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  rbd_issue_t           issue;
  logic                 mem_we;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_addr;
  pair_word_t           mem_wdata;
  pair_word_t           mem_rdata;
  logic                 in_ready;

  rbd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .in_ready_i  (in_ready),
    .issue_o     (issue),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  rbd_line_mem #(
    .DEPTH     (LINE_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  rbd_avg u_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue_i (issue),
    .rdata_i (mem_rdata),
    .free_o  (in_ready),
    .out_ch  (out_ch)
  );

endmodule
